// ----- rtl/csmi_pkg.sv -----
package csmi_pkg;

    localparam int MAX_N_DEF  = 1024;
    localparam int VALUE_W    = 10;
    localparam int VALUE_SPAN = 1024;
    localparam int MIN_LEN    = 4;
    localparam int MIN_INV_W  = 19;
    localparam int BOUND_W    = 18;
    localparam int STATUS_W   = 2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LENGTH  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTPERM = 2'd2;

endpackage

// ----- rtl/csmi_ram.sv -----
module csmi_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cyclic_shift_min_inversions_core.sv -----
// Collects a permutation one value per start transfer (busy is high for one cycle after each
// item but the last); the transfer with i_last set closes the set and, once the search (skipped
// for an invalid set) is done, one result is shown on the o_ ports for a single cycle with
// o_valid high. The receiver cannot stall it. For a valid set of length n, after the last item
// the block fills the inverse store in one pass of the position store, counts inversions with
// one read of the position store per pair compare, then reads the inverse store once per
// rotation and value shift, each step doing one memory read per cycle. Every set, valid or not,
// ends with a pass that clears all 1024 seen marks; the same pass runs after reset, with busy high.
module cyclic_shift_min_inversions_core
    import csmi_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [VALUE_W-1:0]   i_value,
    input  logic                 i_last,
    output logic                 o_valid,
    output logic [MIN_INV_W-1:0] o_min_inversions,
    output logic [BOUND_W-1:0]   o_bound,
    output logic                 o_exceeds_bound,
    output logic [STATUS_W-1:0]  o_status
);

    localparam int AW   = $clog2(MAX_N);
    localparam int NW   = $clog2(MAX_N + 2);
    localparam int CW   = $clog2(MAX_N * (MAX_N - 1) / 2 + 1);
    localparam int BW   = 2 * NW;
    localparam int CMPW = (NW > VALUE_W) ? NW : VALUE_W;
    localparam int KW   = (CW > BW) ? CW : BW;
    localparam int SW   = $clog2(VALUE_SPAN);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_CHK    = 13'b0000000000010,
        S_FIN    = 13'b0000000000100,
        S_BUILD  = 13'b0000000001000,
        S_BDRAIN = 13'b0000000010000,
        S_CHEAD  = 13'b0000000100000,
        S_CROW   = 13'b0000001000000,
        S_CDRAIN = 13'b0000010000000,
        S_SSTART = 13'b0000100000000,
        S_SROW   = 13'b0001000000000,
        S_SDRAIN = 13'b0010000000000,
        S_OUT    = 13'b0100000000000,
        S_CLR    = 13'b1000000000000
    } t_state;

    t_state              r_state, n_state;
    logic [NW-1:0]       r_cnt;
    logic [1:0]          r_bad;
    logic [VALUE_W-1:0]  r_max;
    logic [VALUE_W-1:0]  r_val;
    logic                r_last;
    logic                r_stored;
    logic [SW-1:0]       r_clr;
    logic [STATUS_W-1:0] r_status;
    logic [BW-1:0]       r_bound;
    logic [AW-1:0]       r_i, r_id, r_j, r_a, r_b;
    logic                r_bv, r_chv, r_crv, r_v0, r_v1, r_v2;
    logic [VALUE_W-1:0]  r_pi;
    logic [CW-1:0]       r_rot, r_sh, r_best, r_delta;
    logic                r_ov;
    logic [MIN_INV_W-1:0] r_omin;
    logic [BOUND_W-1:0]  r_obound;
    logic                r_oexc;
    logic [STATUS_W-1:0] r_ostatus;

    logic                accept;
    logic                room;
    logic [NW-1:0]       n_last, n_prev;
    logic [NW:0]         s_sum;
    logic [AW-1:0]       p_rot;
    logic [STATUS_W-1:0] fin_status;
    logic [NW-1:0]       len_m1;

    logic                perm_we;
    logic [AW-1:0]       perm_addr;
    logic [VALUE_W-1:0]  perm_rdata;
    logic                inv_we;
    logic [AW-1:0]       inv_addr;
    logic [AW-1:0]       inv_rdata;
    logic                seen_we;
    logic [SW-1:0]       seen_addr;
    logic                seen_wdata;
    logic                seen_rdata;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign room   = (r_cnt < NW'(MAX_N));
    assign n_last = r_cnt - NW'(1);
    assign n_prev = r_cnt - NW'(2);
    assign len_m1 = r_cnt - NW'(1);

    // rotated position of the wrapping value: (inv + n - a) mod n
    always_comb begin
        s_sum = (NW+1)'(inv_rdata) + (NW+1)'(r_cnt) - (NW+1)'(r_a);
        if (s_sum >= (NW+1)'(r_cnt)) begin
            s_sum = s_sum - (NW+1)'(r_cnt);
        end
        p_rot = AW'(s_sum);
    end

    always_comb begin
        if (r_cnt < NW'(MIN_LEN) || r_cnt > NW'(MAX_N) || r_bad[0]) begin
            fin_status = ST_LENGTH;
        end else if (r_bad[1] || CMPW'(r_max) >= CMPW'(r_cnt)) begin
            fin_status = ST_NOTPERM;
        end else begin
            fin_status = ST_OK;
        end
    end

    always_comb begin
        perm_we   = 1'b0;
        perm_addr = r_i;
        unique case (r_state) inside
            S_IDLE: begin
                perm_we   = accept && room;
                perm_addr = AW'(r_cnt);
            end
            S_CROW:                      perm_addr = r_j;
            S_SSTART, S_SROW, S_SDRAIN:  perm_addr = r_a;
            default:                     perm_addr = r_i;
        endcase
    end

    assign inv_we   = r_bv;
    assign inv_addr = r_bv ? AW'(perm_rdata) : r_b;

    always_comb begin
        seen_we    = 1'b0;
        seen_addr  = SW'(i_value);
        seen_wdata = 1'b1;
        unique case (r_state)
            S_CHK: begin
                seen_we   = r_stored;
                seen_addr = SW'(r_val);
            end
            S_CLR: begin
                seen_we    = 1'b1;
                seen_addr  = r_clr;
                seen_wdata = 1'b0;
            end
            default: seen_addr = SW'(i_value);
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept) n_state = S_CHK;
            S_CHK:    n_state = r_last ? S_FIN : S_IDLE;
            S_FIN:    n_state = (fin_status == ST_OK) ? S_BUILD : S_OUT;
            S_BUILD:  if (AW'(n_last) == r_i) n_state = S_BDRAIN;
            S_BDRAIN: n_state = S_CHEAD;
            S_CHEAD:  n_state = S_CROW;
            S_CROW: begin
                if (AW'(n_last) == r_j) begin
                    n_state = (AW'(n_prev) == r_i) ? S_CDRAIN : S_CHEAD;
                end
            end
            S_CDRAIN: n_state = S_SSTART;
            S_SSTART: n_state = S_SROW;
            S_SROW:   if (AW'(n_prev) == r_b) n_state = S_SDRAIN;
            S_SDRAIN: begin
                if (!(r_v0 || r_v1 || r_v2)) begin
                    n_state = (AW'(n_last) == r_a) ? S_OUT : S_SSTART;
                end
            end
            S_OUT:    n_state = S_CLR;
            S_CLR:    if (r_clr == SW'(VALUE_SPAN - 1)) n_state = S_IDLE;
            default:  n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt   <= '0;
            r_bad   <= '0;
            r_max   <= '0;
            r_clr   <= '0;
            r_bv    <= 1'b0;
            r_chv   <= 1'b0;
            r_crv   <= 1'b0;
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bv    <= (r_state == S_BUILD);
            r_chv   <= (r_state == S_CHEAD);
            r_crv   <= (r_state == S_CROW);
            r_v0    <= (r_state == S_SROW);
            r_v1    <= r_v0;
            r_v2    <= r_v1 || (r_state == S_SSTART);
            r_ov    <= (r_state == S_OUT);
            if (accept) begin
                if (room) begin
                    r_cnt <= r_cnt + NW'(1);
                    if (i_value > r_max) r_max <= i_value;
                end else begin
                    r_cnt    <= NW'(MAX_N + 1);
                    r_bad[0] <= 1'b1;
                end
            end
            if (r_state == S_CHK && r_stored && seen_rdata) begin
                r_bad[1] <= 1'b1;
            end
            if (r_state == S_CLR) begin
                r_clr <= r_clr + SW'(1);
                r_cnt <= '0;
                r_bad <= '0;
                r_max <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_val    <= i_value;
            r_last   <= i_last;
            r_stored <= room;
        end
        r_id <= r_i;
        unique case (r_state)
            S_FIN: begin
                r_status <= fin_status;
                r_bound  <= (fin_status == ST_LENGTH) ? '0
                                : ((BW'(len_m1) * BW'(len_m1)) >> 2);
                r_i      <= '0;
                r_a      <= '0;
                r_rot    <= '0;
            end
            S_BUILD:  r_i <= (AW'(n_last) == r_i) ? '0 : r_i + AW'(1);
            S_CHEAD:  r_j <= r_i + AW'(1);
            S_CROW: begin
                r_j <= r_j + AW'(1);
                if (AW'(n_last) == r_j) r_i <= r_i + AW'(1);
            end
            S_SSTART: begin
                r_b <= '0;
                if (r_a == '0) r_best <= r_rot;
            end
            S_SROW:   r_b <= r_b + AW'(1);
            S_SDRAIN: begin
                if (!(r_v0 || r_v1 || r_v2)) begin
                    r_rot <= r_rot + CW'(len_m1) - (CW'(perm_rdata) << 1);
                    r_a   <= r_a + AW'(1);
                end
            end
            S_OUT: begin
                r_ostatus <= r_status;
                r_obound  <= BOUND_W'(r_bound);
                r_omin    <= (r_status == ST_OK) ? MIN_INV_W'(r_best) : '0;
                r_oexc    <= (r_status == ST_OK) && (KW'(r_best) > KW'(r_bound));
            end
            default: ;
        endcase
        if (r_chv) r_pi <= perm_rdata;
        if (r_crv && r_pi > perm_rdata) r_rot <= r_rot + CW'(1);
        if (r_v0) r_delta <= CW'(len_m1) - (CW'(p_rot) << 1);
        if (r_state == S_SSTART) begin
            r_sh <= r_rot;
        end else if (r_v1) begin
            r_sh <= r_sh + r_delta;
        end
        if (r_v2 && r_sh < r_best) r_best <= r_sh;
    end

    csmi_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_N)) u_perm (
        .i_clk   (i_clk),
        .i_we    (perm_we),
        .i_addr  (perm_addr),
        .i_wdata (i_value),
        .o_rdata (perm_rdata)
    );

    csmi_ram #(.WIDTH(AW), .DEPTH(MAX_N)) u_inv (
        .i_clk   (i_clk),
        .i_we    (inv_we),
        .i_addr  (inv_addr),
        .i_wdata (r_id),
        .o_rdata (inv_rdata)
    );

    csmi_ram #(.WIDTH(1), .DEPTH(VALUE_SPAN)) u_seen (
        .i_clk   (i_clk),
        .i_we    (seen_we),
        .i_addr  (seen_addr),
        .i_wdata (seen_wdata),
        .o_rdata (seen_rdata)
    );

    assign o_valid          = r_ov;
    assign o_min_inversions = r_omin;
    assign o_bound          = r_obound;
    assign o_exceeds_bound  = r_oexc;
    assign o_status         = r_ostatus;

    a_bad_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_min_inversions == '0 && !o_exceeds_bound))
        else $error("nonzero status with nonzero minimum");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy low after a transfer");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_shift_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SROW) |-> (NW'(r_b) < n_last && NW'(r_a) < r_cnt))
        else $error("shift index beyond set length");

endmodule

// ----- dv/cyclic_shift_min_inversions_core_tb.sv -----
`timescale 1ns / 1ps

module cyclic_shift_min_inversions_core_tb;
    import csmi_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int DRAIN_CYCLES = 1200;

    typedef struct packed {
        logic [MIN_INV_W-1:0] minv;
        logic [BOUND_W-1:0]   bnd;
        logic                 exc;
        logic [STATUS_W-1:0]  st;
    } t_inv_result;

    typedef struct {
        logic [VALUE_W-1:0] v;
        bit                 l;
        bit                 typed;
        t_inv_result        res;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [VALUE_W-1:0]   i_value = '0;
    logic                 i_last = 1'b0;
    logic                 o_valid;
    logic [MIN_INV_W-1:0] o_min_inversions;
    logic [BOUND_W-1:0]   o_bound;
    logic                 o_exceeds_bound;
    logic [STATUS_W-1:0]  o_status;

    cyclic_shift_min_inversions_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_value         (i_value),
        .i_last          (i_last),
        .o_valid         (o_valid),
        .o_min_inversions(o_min_inversions),
        .o_bound         (o_bound),
        .o_exceeds_bound (o_exceeds_bound),
        .o_status        (o_status)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    int          set_perm [MAX_N_DEF];
    bit          set_seen [VALUE_SPAN];
    int          set_count;
    int          set_bad;
    t_inv_result pending_results[$];
    t_stim_row   stim_rows[$];

    int error_count = 0;
    int cycle_count = 0;
    int burst_left;

    function automatic int least_inversions(int n);
        int pos_of [MAX_N_DEF];
        int rot;
        int sh;
        int best;
        int p;
        for (int i = 0; i < n; i++) pos_of[set_perm[i]] = i;
        rot = 0;
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
                if (set_perm[i] > set_perm[j]) rot++;
        best = rot;
        for (int a = 0; a < n; a++) begin
            sh = rot;
            if (sh < best) best = sh;
            for (int b = 0; b + 1 < n; b++) begin
                p = (pos_of[b] + n - a) % n;
                sh += n - 1 - 2 * p;
                if (sh < best) best = sh;
            end
            rot += n - 1 - 2 * set_perm[a];
        end
        return best;
    endfunction

    // Fold one accepted transfer into the predictor; push the result when a set closes.
    task automatic absorb_item(input logic [VALUE_W-1:0] v, input bit l);
        t_inv_result r;
        int          n;
        int          minv;
        if (set_count < MAX_N_DEF) begin
            set_perm[set_count] = int'(v);
            if (set_seen[v]) set_bad |= 2;
            set_seen[v] = 1'b1;
            set_count++;
        end else begin
            set_count = MAX_N_DEF + 1;
            set_bad |= 1;
        end
        if (l) begin
            r = '0;
            n = set_count;
            if (n < MIN_LEN || n > MAX_N_DEF || set_bad[0]) begin
                r.st = ST_LENGTH;
            end else begin
                r.st = set_bad[1] ? ST_NOTPERM : ST_OK;
                for (int i = 0; i < n; i++)
                    if (set_perm[i] >= n) r.st = ST_NOTPERM;
                r.bnd = BOUND_W'(((n - 1) * (n - 1)) / 4);
                if (r.st == ST_OK) begin
                    minv = least_inversions(n);
                    r.minv = MIN_INV_W'(minv);
                    r.exc = (minv > int'(r.bnd));
                end
            end
            pending_results.push_back(r);
            foreach (set_seen[i]) set_seen[i] = 1'b0;
            set_count = 0;
            set_bad = 0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Drive one transfer; start stays high across back-to-back items.
    task automatic send_item(input logic [VALUE_W-1:0] v, input bit l);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(1, 12)) begin
                    @(negedge i_clk);
                    start <= 1'b0;
                end
            end
        end
        burst_left--;
        @(negedge i_clk);
        start   <= 1'b1;
        i_value <= v;
        i_last  <= l;
        do @(posedge i_clk); while (busy);
        absorb_item(v, l);
    endtask

    task automatic add_row(input logic [VALUE_W-1:0] v, input bit l, input bit typed,
                           input int minv, input int bnd, input bit exc,
                           input logic [STATUS_W-1:0] st);
        t_stim_row row;
        row.v = v;
        row.l = l;
        row.typed = typed;
        row.res.minv = MIN_INV_W'(minv);
        row.res.bnd = BOUND_W'(bnd);
        row.res.exc = exc;
        row.res.st = st;
        stim_rows.push_back(row);
    endtask

    task automatic send_random_set();
        int n;
        int kind;
        int tmp;
        int j;
        int vals [MAX_N_DEF];
        kind = $urandom_range(0, 9);
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 64) : $urandom_range(4, 12);
        if (kind == 9) n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) vals[i] = i;
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = vals[i];
            vals[i] = vals[j];
            vals[j] = tmp;
        end
        if (kind == 7) vals[$urandom_range(0, n - 1)] = $urandom_range(0, n - 1);
        if (kind == 8) vals[$urandom_range(0, n - 1)] = $urandom_range(0, 1023);
        if (kind == 9)
            for (int i = 0; i < n; i++) vals[i] = $urandom_range(0, 1023);
        for (int i = 0; i < n; i++) send_item(VALUE_W'(vals[i]), i == n - 1);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_inv_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no expectation");
            end else begin
                want = pending_results.pop_front();
                if (o_min_inversions !== want.minv)
                    report_mismatch($sformatf("min_inversions %0d want %0d",
                                              o_min_inversions, want.minv));
                if (o_bound !== want.bnd)
                    report_mismatch($sformatf("bound %0d want %0d", o_bound, want.bnd));
                if (o_exceeds_bound !== want.exc)
                    report_mismatch($sformatf("exceeds_bound %0b want %0b",
                                              o_exceeds_bound, want.exc));
                if (o_status !== want.st)
                    report_mismatch($sformatf("status %0d want %0d", o_status, want.st));
            end
        end
    end

    initial begin
        burst_left = 0;
        set_count = 0;
        set_bad = 0;
        foreach (set_seen[i]) set_seen[i] = 1'b0;

        // too short
        add_row(0, 0, 0, 0, 0, 0, ST_OK);
        add_row(1, 0, 0, 0, 0, 0, ST_OK);
        add_row(2, 1, 1, 0, 0, 0, ST_LENGTH);
        add_row(1023, 1, 1, 0, 0, 0, ST_LENGTH);
        // identity of length 4
        add_row(0, 0, 0, 0, 0, 0, ST_OK);
        add_row(1, 0, 0, 0, 0, 0, ST_OK);
        add_row(2, 0, 0, 0, 0, 0, ST_OK);
        add_row(3, 1, 1, 0, 2, 0, ST_OK);
        // repeated value
        add_row(0, 0, 0, 0, 0, 0, ST_OK);
        add_row(0, 0, 0, 0, 0, 0, ST_OK);
        add_row(1, 0, 0, 0, 0, 0, ST_OK);
        add_row(2, 1, 1, 0, 2, 0, ST_NOTPERM);
        // value out of range
        add_row(0, 0, 0, 0, 0, 0, ST_OK);
        add_row(1, 0, 0, 0, 0, 0, ST_OK);
        add_row(2, 0, 0, 0, 0, 0, ST_OK);
        add_row(1023, 1, 1, 0, 2, 0, ST_NOTPERM);
        // reversed and mixed sets through the predictor
        add_row(3, 0, 0, 0, 0, 0, ST_OK);
        add_row(2, 0, 0, 0, 0, 0, ST_OK);
        add_row(1, 0, 0, 0, 0, 0, ST_OK);
        add_row(0, 1, 0, 0, 0, 0, ST_OK);
        add_row(4, 0, 0, 0, 0, 0, ST_OK);
        add_row(1, 0, 0, 0, 0, 0, ST_OK);
        add_row(3, 0, 0, 0, 0, 0, ST_OK);
        add_row(0, 0, 0, 0, 0, 0, ST_OK);
        add_row(2, 1, 0, 0, 0, 0, ST_OK);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            send_item(stim_rows[k].v, stim_rows[k].l);
            if (stim_rows[k].typed) begin
                void'(pending_results.pop_back());
                pending_results.push_back(stim_rows[k].res);
            end
        end

        for (int s = 0; s < 45; s++) begin
            send_random_set();
            if (s == 20) begin
                // hold off until the pipeline has drained
                while (pending_results.size() != 0) @(posedge i_clk);
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
